// ----- src/pur_pkg.sv -----
`timescale 1ns / 1ps

package pur_pkg;

    localparam int MAX_SIZE_DEF = 8;
    localparam int RANK_W       = 16;
    localparam int SIZE_W       = 4;
    localparam int FIELD_W      = 3;
    localparam int M_DATA_W     = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Reciprocal divide: q = (x * RECIP[d]) >> RECIP_SHIFT is exact or one low for 16-bit x.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = RANK_W + RECIP_W;
    localparam int REM_W       = RANK_W + SIZE_W;

    // floor(2^20 / d), entry zero unused
    localparam logic [RECIP_W-1:0] RECIP [16] = '{
        21'd0,      21'd1048576, 21'd524288, 21'd349525,
        21'd262144, 21'd209715,  21'd174762, 21'd149796,
        21'd131072, 21'd116508,  21'd104857, 21'd95325,
        21'd87381,  21'd80659,   21'd74898,  21'd69905
    };

    typedef struct packed {
        logic load;
        logic div_mul;
        logic div_fix;
        logic perm_step;
    } cmd_t;

    typedef struct packed {
        logic j_last;
        logic out_free;
    } status_t;

endpackage

// ----- src/pur_ctrl.sv -----
`timescale 1ns / 1ps

module pur_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pur_pkg::status_t status,
    output pur_pkg::cmd_t    cmd
);
    import pur_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_PERM
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.div_mul = 1'b1;
                state_next  = S_FIX;
            end
            S_FIX: begin
                cmd.div_fix = 1'b1;
                state_next  = status.j_last ? S_PERM : S_MUL;
            end
            S_PERM: begin
                if (status.out_free) begin
                    cmd.perm_step = 1'b1;
                    if (status.j_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/pur_datapath.sv -----
`timescale 1ns / 1ps

module pur_datapath #(
    parameter int MAX_SIZE = pur_pkg::MAX_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pur_pkg::cmd_t                 cmd,
    output pur_pkg::status_t              status,
    input  logic [pur_pkg::RANK_W-1:0]    s_rank,
    input  logic                          cfg_we,
    input  logic [pur_pkg::SIZE_W-1:0]    cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pur_pkg::FIELD_W-1:0]   m_position,
    output logic [pur_pkg::FIELD_W-1:0]   m_element,
    output logic [pur_pkg::FIELD_W-1:0]   m_digit,
    output logic                          m_last
);
    import pur_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIZE);

    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  n_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [RANK_W-1:0]  rest_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [IDX_W-1:0]   digit_reg [MAX_SIZE];
    logic [IDX_W-1:0]   seq_reg   [MAX_SIZE];
    logic               out_valid_reg;
    logic [FIELD_W-1:0] pos_reg;
    logic [FIELD_W-1:0] elem_reg;
    logic [FIELD_W-1:0] dig_reg;
    logic               last_reg;

    logic [SIZE_W-1:0]  base;
    logic [RANK_W-1:0]  q_low;
    logic [REM_W-1:0]   r_wide;
    logic [RANK_W-1:0]  q_fix;
    logic [REM_W-1:0]   r_fix;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W:0]     src;
    logic [IDX_W-1:0]   picked;
    logic               j_last;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] n;
        n = v;
        if (n == '0) begin
            n = SIZE_W'(1);
        end
        if (n > SIZE_W'(MAX_SIZE)) begin
            n = SIZE_W'(MAX_SIZE);
        end
        return n;
    endfunction

    assign j_last = (SIZE_W'(j_reg) == n_reg - SIZE_W'(1));
    assign base   = SIZE_W'(j_reg) + SIZE_W'(1);
    assign wr_idx = IDX_W'(n_reg - SIZE_W'(1) - SIZE_W'(j_reg));

    // Correct the reciprocal quotient, which is at most one low
    always_comb begin
        q_low  = prod_reg[RECIP_SHIFT +: RANK_W];
        r_wide = REM_W'(rest_reg) - REM_W'(q_low) * REM_W'(base);
        q_fix  = q_low;
        r_fix  = r_wide;
        if (r_wide >= REM_W'(base)) begin
            q_fix = q_low + RANK_W'(1);
            r_fix = r_wide - REM_W'(base);
        end
    end

    assign src    = (IDX_W+1)'(j_reg) + (IDX_W+1)'(digit_reg[j_reg]);
    assign picked = seq_reg[src[IDX_W-1:0]];

    assign status.j_last   = j_last;
    assign status.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= clamp_size(SIZE_RESET);
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                size_reg <= clamp_size(cfg_data);
            end
            if (cmd.load) begin
                j_reg <= '0;
            end else if (cmd.div_fix || cmd.perm_step) begin
                j_reg <= j_last ? '0 : j_reg + IDX_W'(1);
            end
            if (cmd.perm_step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rest_reg <= s_rank;
            n_reg    <= size_reg;
            for (int k = 0; k < MAX_SIZE; k++) begin
                seq_reg[k] <= IDX_W'(k);
            end
        end
        if (cmd.div_mul) begin
            prod_reg <= PROD_W'(rest_reg) * PROD_W'(RECIP[base]);
        end
        if (cmd.div_fix) begin
            rest_reg          <= q_fix;
            digit_reg[wr_idx] <= r_fix[IDX_W-1:0];
        end
        if (cmd.perm_step) begin
            for (int k = 0; k < MAX_SIZE; k++) begin
                if (k == int'(j_reg)) begin
                    seq_reg[k] <= picked;
                end else if (k > int'(j_reg) && k <= int'(src)) begin
                    seq_reg[k] <= seq_reg[(k == 0) ? 0 : k - 1];
                end
            end
            pos_reg  <= FIELD_W'(j_reg);
            elem_reg <= FIELD_W'(picked);
            dig_reg  <= FIELD_W'(digit_reg[j_reg]);
            last_reg <= j_last;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_position = pos_reg;
    assign m_element  = elem_reg;
    assign m_digit    = dig_reg;
    assign m_last     = last_reg;

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_fix |-> (r_wide < (REM_W'(base) << 1)))
        else $error("reciprocal quotient off by more than one");

    a_src_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.perm_step |-> (SIZE_W'(src) < n_reg))
        else $error("selected element beyond permutation size");

    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.perm_step && j_last) |=> (j_reg == '0))
        else $error("position counter not rewound after last result");

endmodule

// ----- src/permutation_unrank_core.sv -----
`timescale 1ns / 1ps
// Sequence: after an item is accepted, the shared reciprocal divider produces its factorial
//   digits with a multiply step and a fix step per digit, then the output register emits the
//   n positions (n = perm_size), one result per cycle while m_tready does not hold it. A new
//   item is accepted only after the last position of the previous one enters the output register.
// Reset (aresetn low, synchronous): perm_size returns to 8 capped at MAX_SIZE, no item pending.

module permutation_unrank_core #(
    parameter int MAX_SIZE = pur_pkg::MAX_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pur_pkg::RANK_W-1:0]     s_tdata,   // [15:0] rank_index
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pur_pkg::M_DATA_W-1:0]   m_tdata,   // [2:0] position, [5:3] element,
                                                      // [8:6] lehmer_digit, [15:9] zero
    output logic                           m_tlast,
    // Configuration: perm_size
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pur_pkg::SIZE_W-1:0]     cfg_data
);
    import pur_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] element;
    logic [FIELD_W-1:0] lehmer_digit;

    // Always take configuration writes; the size is latched per item at accept,
    // so a new value applies from the next accepted item on.
    assign cfg_ready = 1'b1;

    // Sequencer: accept, two steps per digit, then one emit step per position.
    pur_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Digit divider, permutation register row and output register.
    pur_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_rank     (s_tdata),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_position (position),
        .m_element  (element),
        .m_digit    (lehmer_digit),
        .m_last     (m_tlast)
    );

    // Pack result fields, lowest field first, zero fill to whole bytes.
    assign m_tdata = {(M_DATA_W - 3 * FIELD_W)'(0), lehmer_digit, element, position};

endmodule
